// ===== sv/stcp_pkg.sv =====
// Shared types, codes and the step table of the servo tuning command parser.
package stcp_pkg;

  localparam int PULSE_W = 12;
  localparam int STEP_W  = 6;

  localparam logic [PULSE_W-1:0] RESET_CEILING = 12'd500;
  localparam logic [PULSE_W-1:0] RESET_PULSE   = 12'd300;
  localparam logic [2:0]         RESET_SLOT    = 3'd2;
  localparam logic [2:0]         SLOT_COUNT    = 3'd5;

  // configuration register indexes
  localparam logic CFG_CEILING = 1'b0;
  localparam logic CFG_CENTER  = 1'b1;

  // response codes
  localparam logic [3:0] RESP_SERVO_SEL = 4'd0;
  localparam logic [3:0] RESP_PAIR_SEL  = 4'd1;
  localparam logic [3:0] RESP_VALUE     = 4'd2;
  localparam logic [3:0] RESP_LIMIT     = 4'd3;
  localparam logic [3:0] RESP_STEP      = 4'd4;
  localparam logic [3:0] RESP_STATUS    = 4'd5;
  localparam logic [3:0] RESP_CENTERED  = 4'd6;
  localparam logic [3:0] RESP_SWEEP     = 4'd7;
  localparam logic [3:0] RESP_REFUSED   = 4'd8;
  localparam logic [3:0] RESP_SELECTION = 4'd9;
  localparam logic [3:0] RESP_HELP      = 4'd10;
  localparam logic [3:0] RESP_INVALID   = 4'd11;

  // command characters
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_C  = 8'h63;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_P  = 8'h70;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  // decoded command
  typedef struct packed {
    logic       emit;        // produces at least one result word
    logic       calc;        // needs the step unit before results go out
    logic       pair;        // step both servos of the pair
    logic       up;          // direction for the first servo
    logic       set_center;  // write center_pulse at each emitted channel
    logic       no_servo;    // channel and value read as zero
    logic       set_servo;
    logic       set_pair;
    logic       step_adv;
    logic       prefix_set;
    logic [1:0] finger;
    logic [3:0] resp;
    logic [2:0] base;
    logic [2:0] last_idx;
  } dec_t;

  typedef struct packed {
    logic               ok;
    logic [PULSE_W-1:0] value;
  } alu_res_t;

  function automatic logic [STEP_W-1:0] step_of(input logic [2:0] slot);
    logic [STEP_W-1:0] s;
    case (slot)
      3'd0:    s = 6'd1;
      3'd1:    s = 6'd5;
      3'd2:    s = 6'd10;
      3'd3:    s = 6'd20;
      3'd4:    s = 6'd50;
      default: s = 6'd1;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/stcp_decode.sv =====
// Command byte decoder: turns one received byte and the selection state into a command.
module stcp_decode #(
  parameter int NUM_SERVOS = 8
) (
  input  logic [7:0]   rx_byte,
  input  logic         prefix_pending,
  input  logic         single_select,
  input  logic [2:0]   current_servo,
  input  logic [1:0]   current_finger,
  output stcp_pkg::dec_t dec
);
  import stcp_pkg::*;

  localparam logic [3:0] NS      = 4'(NUM_SERVOS);
  localparam logic [2:0] LAST_CH = 3'(NUM_SERVOS - 1);

  logic [7:0] lc;
  logic       is_digit;
  logic       is_pair_digit;
  logic [2:0] pair_base;
  logic [2:0] sel_base;

  assign lc            = rx_byte | CASE_BIT;
  assign is_digit      = (rx_byte >= CH_ZERO) && (rx_byte <= CH_SEVEN) &&
                         ({1'b0, rx_byte[2:0]} < NS);
  assign is_pair_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_THREE) &&
                         ({1'b0, rx_byte[1:0], 1'b1} < NS);
  assign pair_base     = {current_finger, 1'b0};
  assign sel_base      = single_select ? current_servo : pair_base;

  always_comb begin
    dec          = '0;
    dec.emit     = 1'b1;
    dec.resp     = RESP_INVALID;
    dec.no_servo = 1'b1;
    if (prefix_pending) begin
      if (is_pair_digit) begin
        dec.set_pair = 1'b1;
        dec.finger   = rx_byte[1:0];
        dec.resp     = RESP_PAIR_SEL;
        dec.no_servo = 1'b0;
        dec.base     = {rx_byte[1:0], 1'b0};
        dec.last_idx = 3'd1;
      end
    end else if (is_digit) begin
      dec.set_servo = 1'b1;
      dec.resp      = RESP_SERVO_SEL;
      dec.no_servo  = 1'b0;
      dec.base      = rx_byte[2:0];
    end else if (lc == CH_LOW_F) begin
      dec.emit       = 1'b0;
      dec.prefix_set = 1'b1;
    end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
      dec.calc     = 1'b1;
      dec.pair     = !single_select;
      dec.up       = (rx_byte == CH_PLUS);
      dec.resp     = RESP_VALUE;
      dec.no_servo = 1'b0;
      dec.base     = sel_base;
      dec.last_idx = {2'b00, !single_select};
    end else if (lc == CH_LOW_S) begin
      dec.resp     = RESP_STATUS;
      dec.no_servo = 1'b0;
      dec.last_idx = LAST_CH;
    end else if (lc == CH_LOW_C) begin
      dec.resp       = RESP_CENTERED;
      dec.no_servo   = 1'b0;
      dec.set_center = 1'b1;
      dec.last_idx   = LAST_CH;
    end else if (lc == CH_LOW_N) begin
      dec.step_adv = 1'b1;
      dec.resp     = RESP_STEP;
    end else if (lc == CH_LOW_A) begin
      if (!single_select) begin
        dec.resp       = RESP_SWEEP;
        dec.no_servo   = 1'b0;
        dec.set_center = 1'b1;
        dec.base       = pair_base;
        dec.last_idx   = 3'd1;
      end else begin
        dec.resp = RESP_REFUSED;
      end
    end else if (lc == CH_LOW_P) begin
      dec.resp     = RESP_SELECTION;
      dec.no_servo = 1'b0;
      dec.base     = sel_base;
      dec.last_idx = {2'b00, !single_select};
    end else if (lc == CH_LOW_H) begin
      dec.resp = RESP_HELP;
    end
  end

endmodule

// ===== sv/stcp_alu.sv =====
// Shared step unit: one add or subtract with its limit compare.
module stcp_alu (
  input  logic [11:0]         value,
  input  logic [5:0]          step,
  input  logic [11:0]         ceiling,
  input  logic                up,
  output stcp_pkg::alu_res_t  res
);
  import stcp_pkg::*;

  logic [12:0] sum;
  logic [12:0] step_ext;

  assign step_ext = {7'b0, step};
  assign sum      = up ? ({1'b0, value} + step_ext) : ({1'b0, value} - step_ext);

  // up: fits under the ceiling; down: no borrow out of the subtract
  assign res.ok    = up ? (sum <= {1'b0, ceiling}) : !sum[12];
  assign res.value = sum[11:0];

endmodule

// ===== sv/servo_tuning_command_parser_core.sv =====
// Top level of the servo tuning command parser: sequencer, pulse bank and output register.
//
// Use: command bytes enter on the s_axis channel, one ASCII character per word.
// Each byte yields zero to NUM_SERVOS result words on m_axis; tlast marks the
// final word caused by that byte, tuser carries the response code.
// Registers pulse_ceiling (index 0) and center_pulse (index 1) are written on
// the cfg channel, which is always ready; write them only while no byte is
// in progress.
// Timing: a byte is taken, then the step unit steps each servo of the command in
// turn (none, one or two), then one result word is loaded per cycle while m_axis
// is not stalled. The single add/compare unit and the one write port of the pulse
// bank make the servos step one after another. s_axis_tready is high only between
// bytes; a byte may be taken while the last result word still waits.
// Reset: synchronous, active high; all pulses return to 300, ceiling to 500,
// servo 0 selected in single mode, step size 10, no prefix, output empty.
// Stall: when m_axis_tready is low the output word holds and the sequencer
// waits before producing the next one.
module servo_tuning_command_parser_core #(
  parameter int NUM_SERVOS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] channel, [14:3] pulse_value,
                                      // [16:15] finger, [22:17] step_amount,
                                      // [23] write_servo
  output logic [3:0]  m_axis_tuser,   // [3:0] response
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import stcp_pkg::*;

  localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CALC0 = 2'd1;
  localparam logic [1:0] ST_CALC1 = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state;
  logic [PULSE_W-1:0] store [NUM_SERVOS];
  logic [PULSE_W-1:0] pulse_ceiling;
  logic [PULSE_W-1:0] center_pulse;
  logic [2:0]         current_servo;
  logic [1:0]         current_finger;
  logic               single_select;
  logic [2:0]         step_slot;
  logic               prefix_pending;

  // command held while it runs
  logic [3:0]         op_resp;
  logic [2:0]         op_base;
  logic [2:0]         op_last;
  logic               op_pair;
  logic               op_up;
  logic               op_center;
  logic               op_none;
  logic [2:0]         idx;
  logic               w0;
  logic               w1;

  dec_t               dec;
  alu_res_t           alu_res;
  logic [2:0]         rd_ch;
  logic [PULSE_W-1:0] rd_val;
  logic [STEP_W-1:0]  step_cur;
  logic               out_free;
  logic               out_load;
  logic               in_take;
  logic               item_wr;
  logic [2:0]         emit_ch;
  logic [2:0]         slot_next;

  stcp_decode #(.NUM_SERVOS(NUM_SERVOS)) u_decode (
    .rx_byte        (s_axis_tdata),
    .prefix_pending (prefix_pending),
    .single_select  (single_select),
    .current_servo  (current_servo),
    .current_finger (current_finger),
    .dec            (dec)
  );

  assign step_cur = step_of(step_slot);
  assign emit_ch  = op_base + idx;
  always_comb begin
    case (state)
      ST_CALC1: rd_ch = op_base + 3'd1;
      ST_EMIT:  rd_ch = emit_ch;
      default:  rd_ch = op_base;
    endcase
  end
  assign rd_val = store[rd_ch[IDX_W-1:0]];

  stcp_alu u_alu (
    .value   (rd_val),
    .step    (step_cur),
    .ceiling (pulse_ceiling),
    .up      ((state == ST_CALC1) ? !op_up : op_up),
    .res     (alu_res)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == ST_EMIT) && out_free;
  assign cfg_ready     = 1'b1;
  assign slot_next     = (step_slot + 3'd1 >= SLOT_COUNT) ? 3'd0 : step_slot + 3'd1;

  always_comb begin
    case (op_resp)
      RESP_CENTERED, RESP_SWEEP: item_wr = 1'b1;
      RESP_VALUE:                item_wr = (idx == 3'd0) ? w0 : w1;
      default:                   item_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pulse_ceiling  <= RESET_CEILING;
      center_pulse   <= RESET_PULSE;
      current_servo  <= 3'd0;
      current_finger <= 2'd0;
      single_select  <= 1'b1;
      step_slot      <= RESET_SLOT;
      prefix_pending <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        store[i] <= RESET_PULSE;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CEILING) begin
          pulse_ceiling <= cfg_data;
        end else begin
          center_pulse <= cfg_data;
        end
      end
      // load a new word, or drop the one the receiver took
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            prefix_pending <= dec.prefix_set;
            if (dec.set_servo) begin
              current_servo <= dec.base;
              single_select <= 1'b1;
            end
            if (dec.set_pair) begin
              current_finger <= dec.finger;
              single_select  <= 1'b0;
            end
            if (dec.step_adv) begin
              step_slot <= slot_next;
            end
            op_resp   <= dec.resp;
            op_base   <= dec.base;
            op_last   <= dec.last_idx;
            op_pair   <= dec.pair;
            op_up     <= dec.up;
            op_center <= dec.set_center;
            op_none   <= dec.no_servo;
            idx       <= 3'd0;
            w0        <= 1'b0;
            w1        <= 1'b0;
            if (dec.calc) begin
              state <= ST_CALC0;
            end else if (dec.emit) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_CALC0: begin
          w0 <= alu_res.ok;
          if (alu_res.ok) begin
            store[rd_ch[IDX_W-1:0]] <= alu_res.value;
          end
          state <= op_pair ? ST_CALC1 : ST_EMIT;
        end
        ST_CALC1: begin
          w1 <= alu_res.ok;
          if (alu_res.ok) begin
            store[rd_ch[IDX_W-1:0]] <= alu_res.value;
          end
          // neither servo moved: report the limit once
          if (!w0 && !alu_res.ok) begin
            op_resp <= RESP_LIMIT;
            op_last <= 3'd0;
          end
          state <= ST_EMIT;
        end
        default: begin
          if (out_free) begin
            m_axis_tuser  <= op_resp;
            m_axis_tlast  <= (idx == op_last);
            m_axis_tdata  <= {item_wr, step_cur, current_finger,
                              op_none ? 12'd0 : (op_center ? center_pulse : rd_val),
                              op_none ? 3'd0 : emit_ch};
            if (op_center) begin
              store[rd_ch[IDX_W-1:0]] <= center_pulse;
            end
            idx <= idx + 3'd1;
            if (idx == op_last) begin
              state <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/stcp_checker.sv =====
// Port-level checks of the servo tuning command parser, bound to the top level.
module stcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import stcp_pkg::*;

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result word present after reset");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser <= RESP_INVALID)
    else $error("response code out of range");

  a_no_servo_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == RESP_STEP || m_axis_tuser == RESP_REFUSED ||
                      m_axis_tuser == RESP_HELP || m_axis_tuser == RESP_INVALID)
      |-> m_axis_tdata[14:0] == 15'd0 && m_axis_tlast)
    else $error("servo-free result carries channel or value");

  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[23] |->
      m_axis_tuser == RESP_VALUE || m_axis_tuser == RESP_CENTERED ||
      m_axis_tuser == RESP_SWEEP)
    else $error("driver write flagged on a report-only result");

endmodule

bind servo_tuning_command_parser_core stcp_checker u_stcp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb_servo_tuning_command_parser_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the servo tuning command parser core.
module tb_servo_tuning_command_parser_core;
  import stcp_pkg::*;

  localparam int NUM_SERVOS     = 8;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 70;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [3:0]         resp;
    logic [2:0]         chan;
    logic [PULSE_W-1:0] pulse;
    logic [1:0]         finger;
    logic [STEP_W-1:0]  step;
    logic               wr;
    logic               last;
  } reply_t;

  // Tracks the parser state and the replies each command byte must produce.
  class pulse_reply_board;
    logic [PULSE_W-1:0] ceiling;
    logic [PULSE_W-1:0] center;
    logic [PULSE_W-1:0] bank[NUM_SERVOS];
    logic [2:0]         servo;
    logic [1:0]         finger;
    logic               single;
    logic [2:0]         slot;
    logic               prefix;
    logic [STEP_W-1:0]  step_sizes[5];
    reply_t             due_replies[$];
    reply_t             burst[$];
    int                 fails;

    function new();
      ceiling = RESET_CEILING;
      center  = RESET_PULSE;
      foreach (bank[i]) bank[i] = RESET_PULSE;
      servo  = 3'd0;
      finger = 2'd0;
      single = 1'b1;
      slot   = RESET_SLOT;
      prefix = 1'b0;
      step_sizes = '{6'd1, 6'd5, 6'd10, 6'd20, 6'd50};
      fails = 0;
    endfunction

    function void set_reg(logic idx, logic [PULSE_W-1:0] v);
      if (idx == CFG_CEILING) ceiling = v;
      else center = v;
    endfunction

    function void emit(logic [3:0] resp, logic [2:0] ch, logic [PULSE_W-1:0] v, logic wr);
      reply_t r;
      r.resp   = resp;
      r.chan   = ch;
      r.pulse  = v;
      r.finger = finger;
      r.step   = step_sizes[slot];
      r.wr     = wr;
      r.last   = 1'b0;
      burst.push_back(r);
    endfunction

    function void emit_servo(logic [3:0] resp, logic [2:0] ch, logic wr);
      emit(resp, ch, bank[ch], wr);
    endfunction

    function logic try_up(logic [2:0] ch);
      logic [STEP_W-1:0] s;
      s = step_sizes[slot];
      if (int'(bank[ch]) + int'(s) <= int'(ceiling)) begin
        bank[ch] = bank[ch] + PULSE_W'(s);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic try_down(logic [2:0] ch);
      logic [STEP_W-1:0] s;
      s = step_sizes[slot];
      if (int'(bank[ch]) >= int'(s)) begin
        bank[ch] = bank[ch] - PULSE_W'(s);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void report_selection(logic [3:0] resp);
      if (single) begin
        emit_servo(resp, servo, 1'b0);
      end else begin
        emit_servo(resp, {finger, 1'b0}, 1'b0);
        emit_servo(resp, {finger, 1'b1}, 1'b0);
      end
    endfunction

    function void take_byte(logic [7:0] c);
      logic [7:0] lc;
      logic [2:0] b0;
      logic [2:0] b1;
      logic       w0;
      logic       w1;
      reply_t     r;
      lc = c | CASE_BIT;
      b0 = {finger, 1'b0};
      b1 = {finger, 1'b1};
      if (prefix) begin
        prefix = 1'b0;
        if (c >= CH_ZERO && c <= CH_THREE && int'(c - CH_ZERO) * 2 + 1 < NUM_SERVOS) begin
          finger = 2'(c - CH_ZERO);
          single = 1'b0;
          report_selection(RESP_PAIR_SEL);
        end else begin
          emit(RESP_INVALID, 3'd0, '0, 1'b0);
        end
      end else if (c >= CH_ZERO && c <= CH_SEVEN && int'(c - CH_ZERO) < NUM_SERVOS) begin
        servo  = 3'(c - CH_ZERO);
        single = 1'b1;
        emit_servo(RESP_SERVO_SEL, servo, 1'b0);
      end else if (lc == CH_LOW_F) begin
        prefix = 1'b1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        if (single) begin
          if (c == CH_PLUS) w0 = try_up(servo);
          else w0 = try_down(servo);
          emit_servo(RESP_VALUE, servo, w0);
        end else begin
          // the pair moves in opposite directions
          if (c == CH_PLUS) begin
            w0 = try_up(b0);
            w1 = try_down(b1);
          end else begin
            w0 = try_down(b0);
            w1 = try_up(b1);
          end
          if (!w0 && !w1) begin
            emit_servo(RESP_LIMIT, b0, 1'b0);
          end else begin
            emit_servo(RESP_VALUE, b0, w0);
            emit_servo(RESP_VALUE, b1, w1);
          end
        end
      end else if (lc == CH_LOW_S) begin
        for (int i = 0; i < NUM_SERVOS; i++) emit_servo(RESP_STATUS, 3'(i), 1'b0);
      end else if (lc == CH_LOW_C) begin
        for (int i = 0; i < NUM_SERVOS; i++) begin
          bank[i] = center;
          emit_servo(RESP_CENTERED, 3'(i), 1'b1);
        end
      end else if (lc == CH_LOW_N) begin
        slot = (slot + 3'd1 >= SLOT_COUNT) ? 3'd0 : slot + 3'd1;
        emit(RESP_STEP, 3'd0, '0, 1'b0);
      end else if (lc == CH_LOW_A) begin
        if (!single) begin
          bank[b0] = center;
          bank[b1] = center;
          emit_servo(RESP_SWEEP, b0, 1'b1);
          emit_servo(RESP_SWEEP, b1, 1'b1);
        end else begin
          emit(RESP_REFUSED, 3'd0, '0, 1'b0);
        end
      end else if (lc == CH_LOW_P) begin
        report_selection(RESP_SELECTION);
      end else if (lc == CH_LOW_H) begin
        emit(RESP_HELP, 3'd0, '0, 1'b0);
      end else begin
        emit(RESP_INVALID, 3'd0, '0, 1'b0);
      end
      // mark the final word of this byte
      if (burst.size() > 0) begin
        r = burst.pop_back();
        r.last = 1'b1;
        burst.push_back(r);
      end
      while (burst.size() > 0) due_replies.push_back(burst.pop_front());
    endfunction

    function void take_word(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("unexpected word: resp %0d ch %0d pulse %0d finger %0d step %0d wr %0b last %0b",
                   got.resp, got.chan, got.pulse, got.finger, got.step, got.wr, got.last);
        return;
      end
      want = due_replies.pop_front();
      if (got.resp !== want.resp || got.chan !== want.chan || got.pulse !== want.pulse ||
          got.finger !== want.finger || got.step !== want.step || got.wr !== want.wr ||
          got.last !== want.last) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("mismatch: exp resp %0d ch %0d pulse %0d finger %0d step %0d wr %0b last %0b",
                   want.resp, want.chan, want.pulse, want.finger, want.step, want.wr, want.last);
          $display("          got resp %0d ch %0d pulse %0d finger %0d step %0d wr %0b last %0b",
                   got.resp, got.chan, got.pulse, got.finger, got.step, got.wr, got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = CFG_CEILING;
  logic [11:0] cfg_data      = 12'd0;

  pulse_reply_board board;
  int burst_left = 0;
  int items_sent = 0;
  bit no_gaps    = 1'b0;
  bit hold_req   = 1'b0;

  servo_tuning_command_parser_core #(
    .NUM_SERVOS(NUM_SERVOS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    reply_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) board.take_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[14:3], m_axis_tdata[16:15],
                m_axis_tdata[22:17], m_axis_tdata[23], m_axis_tlast};
        board.take_word(seen);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: stall patterns in random segments, plus one long hold-off on request.
  initial begin : receiver
    int  mode;
    int  left;
    int  tick;
    bit  ready;
    left = 0;
    tick = 0;
    mode = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(1, 60);
        end
        left--;
        tick++;
        case (mode)
          0: ready = 1'b1;
          1: ready = 1'($urandom_range(0, 1));
          2: ready = (tick % 4 == 0);
          default: ready = ($urandom_range(0, 3) != 0);
        endcase
        m_axis_tready <= ready;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] upper(logic [7:0] lower);
    return lower & ~CASE_BIT;
  endfunction

  function automatic logic [7:0] any_case(logic [7:0] lower);
    return $urandom_range(0, 1) ? lower : upper(lower);
  endfunction

  // Offer one command byte; bursts of back-to-back words are separated by random gaps.
  task automatic offer(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if (no_gaps || $urandom_range(0, 3) == 0) gap = 0;
      else gap = $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Drain all expected words, then let a trailing prefix byte finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.due_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_regs(input logic [11:0] ceil, input logic [11:0] ctr);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_CEILING;
    cfg_data  <= ceil;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CENTER;
    cfg_data  <= ctr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      offer(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r < 27) begin
      offer(any_case(CH_LOW_F));
      if ($urandom_range(0, 9) != 0) offer(CH_ZERO + 8'($urandom_range(0, 3)));
      else offer(8'($urandom_range(0, 255)));
    end else if (r < 60) begin
      offer($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    end else if (r < 66) begin
      offer(any_case(CH_LOW_N));
    end else if (r < 70) begin
      offer(any_case(CH_LOW_C));
    end else if (r < 75) begin
      offer(any_case(CH_LOW_A));
    end else if (r < 79) begin
      offer(any_case(CH_LOW_S));
    end else if (r < 83) begin
      offer(any_case(CH_LOW_P));
    end else if (r < 86) begin
      offer(any_case(CH_LOW_H));
    end else begin
      offer(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [11:0] ceil, input logic [11:0] ctr, input bit squeeze);
    int start;
    settle();
    write_regs(ceil, ctr);
    if (squeeze) begin
      no_gaps  = 1'b1;
      hold_req = 1'b1;
    end
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      random_command();
      if (items_sent - start >= 30) no_gaps = 1'b0;
    end
  endtask

  initial begin : stimulus
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    offer(CH_LOW_H);
    offer(upper(CH_LOW_H));
    offer(CH_SEVEN);
    offer(CH_PLUS);
    offer(CH_LOW_N);
    offer(upper(CH_LOW_N));
    offer(CH_LOW_N);
    offer(CH_LOW_N);
    offer(CH_LOW_A);
    offer(CH_LOW_F);
    offer(CH_THREE);
    offer(CH_MINUS);
    offer(upper(CH_LOW_A));
    offer(upper(CH_LOW_F));
    offer(CH_LOW_F);
    offer(CH_LOW_F);
    offer(8'hFF);
    offer(CH_LOW_F);
    offer(CH_THREE + 8'd1);
    offer(CH_SEVEN + 8'd1);
    offer(8'h00);
    offer(CH_LOW_S);
    offer(upper(CH_LOW_C));
    offer(CH_LOW_P);
    offer(CH_ZERO);
    offer(upper(CH_LOW_P));

    // zero ceiling and center: neither servo of the pair can move
    settle();
    write_regs(12'd0, 12'd0);
    offer(CH_LOW_C);
    offer(upper(CH_LOW_F));
    offer(CH_THREE);
    offer(CH_PLUS);
    offer(CH_MINUS);

    run_phase(12'd4095, 12'd4095, 1'b0);
    run_phase(12'd100, 12'd2000, 1'b1);
    run_phase(RESET_CEILING, RESET_PULSE, 1'b0);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0);
    run_phase(12'd4095, 12'd0, 1'b0);
    run_phase(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0);

    settle();
    if (board.fails == 0 && board.due_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
